// ===== rtl/gtpm_pkg.sv =====
// gtpm_pkg: types, constants and rounding helpers for the gyro to pointer block
// no dependencies; imported by gtpm_mul, gtpm_core and gyro_to_pointer_motion_top
package gtpm_pkg;

  localparam int unsigned RATE_W   = 16;
  localparam int unsigned DIFF_W   = 25;
  localparam int unsigned ACC_W    = 32;
  localparam int unsigned OPA_W    = 32;
  localparam int unsigned OPB_W    = 18;
  localparam int unsigned PROD_W   = OPA_W + OPB_W;
  localparam int unsigned CFG_DW   = 17;
  localparam int unsigned CFG_AW   = 3;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_BIAS_X       = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BIAS_Z       = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SCALE_X      = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SCALE_Z      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SMOOTHING    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_POINTER_GAIN = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MOTION_LIMIT = 3'd6;

  typedef struct packed {
    logic signed [15:0] bias_x;
    logic signed [15:0] bias_z;
    logic signed [16:0] scale_x;
    logic signed [16:0] scale_z;
    logic        [16:0] smoothing;
    logic        [16:0] pointer_gain;
    logic        [15:0] motion_limit;
  } gtpm_cfg_t;

  typedef struct packed {
    logic signed [15:0] delta_h;
    logic signed [15:0] delta_v;
    logic               moving;
  } gtpm_res_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // round half up, Q.20 product down to Q.8
  function automatic acc_t rnd12(input prod_t p);
    prod_t s;
    s = p + prod_t'(2048);
    return s[ACC_W+11:12];
  endfunction

  // truncate toward zero by 24 bits, then saturate to 16 bits
  function automatic logic signed [15:0] sat_delta(input prod_t p);
    logic signed [PROD_W-25:0] t;
    logic                      fix;
    fix = p[PROD_W-1] & (|p[23:0]);
    t   = p[PROD_W-1:24] + {{(PROD_W-25){1'b0}}, fix};
    if (t > (PROD_W-24)'(32767)) begin
      return 16'sh7fff;
    end else if (t < -(PROD_W-24)'(32768)) begin
      return 16'sh8000;
    end else begin
      return t[15:0];
    end
  endfunction

endpackage

// ===== rtl/gtpm_mul.sv =====
// gtpm_mul: shared signed 32x18 multiplier with registered product
// depends on gtpm_pkg
module gtpm_mul
  import gtpm_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [OPA_W-1:0] op_a,
  input  logic signed [OPB_W-1:0] op_b,
  output prod_t                   prod
);

  prod_t prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_t'(op_a) * prod_t'(op_b);
    end
  end

  assign prod = prod_r;

endmodule

// ===== rtl/gtpm_core.sv =====
// gtpm_core: step sequencer, filter state and operand selection for both axes
// depends on gtpm_pkg and gtpm_mul
module gtpm_core
  import gtpm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [RATE_W-1:0] rate_x,
  input  logic signed [RATE_W-1:0] rate_z,
  input  gtpm_cfg_t                cfg,
  input  logic                     res_take,
  output logic                     idle,
  output logic                     res_valid,
  output gtpm_res_t                res
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CX   = 4'd1;
  localparam logic [3:0] S_CZ   = 4'd2;
  localparam logic [3:0] S_AX   = 4'd3;
  localparam logic [3:0] S_BX   = 4'd4;
  localparam logic [3:0] S_AZ   = 4'd5;
  localparam logic [3:0] S_BZ   = 4'd6;
  localparam logic [3:0] S_GX   = 4'd7;
  localparam logic [3:0] S_GZ   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]                state_r, state_nxt;
  logic signed [RATE_W-1:0]  rx_r, rz_r;
  acc_t                      corr_x_r, corr_z_r;
  acc_t                      acc_x_r, acc_z_r;
  prod_t                     sum_r;
  logic signed [15:0]        dv_r;

  logic signed [DIFF_W-1:0]  diff_x, diff_z;
  logic [16:0]               alpha, beta, gain;
  logic                      mul_en;
  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  prod_t                     prod;
  prod_t                     sum_all;
  prod_t                     prod_rnd;
  logic [ACC_W-1:0]          mag_x, mag_z, lim;

  assign diff_x = {rx_r[RATE_W-1], rx_r, 8'h00} - DIFF_W'(cfg.bias_x);
  assign diff_z = {rz_r[RATE_W-1], rz_r, 8'h00} - DIFF_W'(cfg.bias_z);
  assign alpha  = (cfg.smoothing > ONE_Q16) ? ONE_Q16 : cfg.smoothing;
  assign beta   = ONE_Q16 - alpha;
  assign gain   = (cfg.pointer_gain > ONE_Q16) ? ONE_Q16 : cfg.pointer_gain;

  always_comb begin
    mul_en = 1'b1;
    op_a   = '0;
    op_b   = '0;
    case (state_r)
      S_CX: begin
        op_a = OPA_W'(diff_x);
        op_b = OPB_W'(cfg.scale_x);
      end
      S_CZ: begin
        op_a = OPA_W'(diff_z);
        op_b = OPB_W'(cfg.scale_z);
      end
      S_AX: begin
        op_a = corr_x_r;
        op_b = {1'b0, alpha};
      end
      S_BX: begin
        op_a = acc_x_r;
        op_b = {1'b0, beta};
      end
      S_AZ: begin
        op_a = corr_z_r;
        op_b = {1'b0, alpha};
      end
      S_BZ: begin
        op_a = acc_z_r;
        op_b = {1'b0, beta};
      end
      S_GX: begin
        op_a = acc_x_r;
        op_b = {1'b0, gain};
      end
      S_GZ: begin
        op_a = acc_z_r;
        op_b = {1'b0, gain};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  gtpm_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign sum_all  = sum_r + prod;
  assign prod_rnd = prod + prod_t'(32768);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_CX;
      S_CX:    state_nxt = S_CZ;
      S_CZ:    state_nxt = S_AX;
      S_AX:    state_nxt = S_BX;
      S_BX:    state_nxt = S_AZ;
      S_AZ:    state_nxt = S_BZ;
      S_BZ:    state_nxt = S_GX;
      S_GX:    state_nxt = S_GZ;
      S_GZ:    state_nxt = S_FIN;
      S_FIN:   if (res_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      acc_x_r <= '0;
      acc_z_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_AZ) acc_x_r <= sum_all[ACC_W+15:16];
      if (state_r == S_GX) acc_z_r <= sum_all[ACC_W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      rx_r <= rate_x;
      rz_r <= rate_z;
    end
    if (state_r == S_CZ) corr_x_r <= rnd12(prod);
    if (state_r == S_AX) corr_z_r <= rnd12(prod);
    if (state_r == S_BX || state_r == S_BZ) sum_r <= prod_rnd;
    if (state_r == S_GZ) dv_r <= sat_delta(prod);
  end

  // magnitudes never reach the sign bit, so plain negation is safe
  assign mag_x = acc_x_r[ACC_W-1] ? ACC_W'(-acc_x_r) : ACC_W'(acc_x_r);
  assign mag_z = acc_z_r[ACC_W-1] ? ACC_W'(-acc_z_r) : ACC_W'(acc_z_r);
  assign lim   = {8'h00, cfg.motion_limit, 8'h00};

  assign idle        = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_FIN);
  assign res.delta_h = sat_delta(prod);
  assign res.delta_v = dv_r;
  assign res.moving  = (mag_x > lim) || (mag_z > lim);

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_CX))
    else $error("sample taken but sequence did not begin");

  a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_take) |=> (state_r == S_IDLE))
    else $error("result handed over but sequencer not idle");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !res_take) |=> (state_r == S_FIN) && $stable(res.delta_h))
    else $error("held result changed before hand-over");

  a_acc_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_x_r[ACC_W-1:28] == '0) || (acc_x_r[ACC_W-1:28] == '1))
    else $error("x filter state out of range");

  a_acc_z_range: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_z_r[ACC_W-1:28] == '0) || (acc_z_r[ACC_W-1:28] == '1))
    else $error("z filter state out of range");

endmodule

// ===== rtl/gyro_to_pointer_motion_top.sv =====
// Gyro to pointer motion filter. A sample beat is taken only while the block is
// idle. One step captures the beat, eight passes go through the single shared
// 32x18 multiplier (bias-corrected scaling, the two filter terms and the pointer
// gain, per axis), and a last step moves the result into the output register.
// The output register lets the next sample start while a result still waits;
// the sequencer then holds in its last step until the register frees. Depends
// on gtpm_pkg, gtpm_core and gtpm_mul.
module gyro_to_pointer_motion_top
  import gtpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // rate_x [15:0], rate_z [31:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // delta_h [15:0], delta_v [31:16]
  output logic [0:0]        out_tuser,  // moving [0]
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  gtpm_cfg_t   cfg_r;
  logic        core_idle;
  logic        res_valid;
  logic        res_take;
  gtpm_res_t   res;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [0:0]  out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias_x       <= '0;
      cfg_r.bias_z       <= '0;
      cfg_r.scale_x      <= 17'sd4096;
      cfg_r.scale_z      <= 17'sd4096;
      cfg_r.smoothing    <= ONE_Q16;
      cfg_r.pointer_gain <= ONE_Q16;
      cfg_r.motion_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BIAS_X:       cfg_r.bias_x       <= cfg_wdata[15:0];
        REG_BIAS_Z:       cfg_r.bias_z       <= cfg_wdata[15:0];
        REG_SCALE_X:      cfg_r.scale_x      <= cfg_wdata;
        REG_SCALE_Z:      cfg_r.scale_z      <= cfg_wdata;
        REG_SMOOTHING:    cfg_r.smoothing    <= cfg_wdata;
        REG_POINTER_GAIN: cfg_r.pointer_gain <= cfg_wdata;
        REG_MOTION_LIMIT: cfg_r.motion_limit <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_tready = core_idle;
  assign res_take  = !out_valid_r || out_tready;

  gtpm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && in_tready),
    .rate_x    (in_tdata[15:0]),
    .rate_z    (in_tdata[31:16]),
    .cfg       (cfg_r),
    .res_take  (res_take),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= {res.delta_v, res.delta_h};
      out_user_r <= res.moving;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sim/gyro_to_pointer_motion_top_tb.sv =====
// testbench for gyro_to_pointer_motion_top: drives gyro sample beats under random
// register settings and checks every pointer delta beat against a fixed-point predictor
// depends on gtpm_pkg and the rtl of gyro_to_pointer_motion_top
module gyro_to_pointer_motion_top_tb;
  import gtpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] REG_SPARE = 3'd7;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 232;
  localparam int MAX_REPORTS = 40;

  typedef enum {RX_OPEN, RX_RANDOM, RX_STALLS} rx_mode_t;

  class motion_scoreboard;
    gtpm_cfg_t regs;
    longint    filt_x;
    longint    filt_z;
    gtpm_res_t due_motion[$];
    int        errors;
    int        n_samples;
    int        n_checked;
    int        n_moving;

    function new();
      regs.bias_x       = '0;
      regs.bias_z       = '0;
      regs.scale_x      = 17'sd4096;
      regs.scale_z      = 17'sd4096;
      regs.smoothing    = ONE_Q16;
      regs.pointer_gain = ONE_Q16;
      regs.motion_limit = '0;
      filt_x = 0;
      filt_z = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      case (idx)
        REG_BIAS_X:       regs.bias_x       = val[15:0];
        REG_BIAS_Z:       regs.bias_z       = val[15:0];
        REG_SCALE_X:      regs.scale_x      = val;
        REG_SCALE_Z:      regs.scale_z      = val;
        REG_SMOOTHING:    regs.smoothing    = val;
        REG_POINTER_GAIN: regs.pointer_gain = val;
        REG_MOTION_LIMIT: regs.motion_limit = val[15:0];
        default: ;
      endcase
    endfunction

    // floor((v + 2^(n-1)) / 2^n)
    function longint round_half_up(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint smooth_axis(longint acc, logic signed [15:0] rate,
                                 logic signed [15:0] bias, logic signed [16:0] scale,
                                 longint alpha);
      longint corr;
      corr = round_half_up((longint'(rate) * 256 - longint'(bias)) * longint'(scale), 12);
      return round_half_up(alpha * corr + (longint'(ONE_Q16) - alpha) * acc, 16);
    endfunction

    function logic signed [15:0] pointer_delta(longint acc, longint gain);
      longint p;
      longint d;
      p = acc * gain;
      d = (p >= 0) ? (p >>> 24) : -((-p) >>> 24);
      if (d > 32767) d = 32767;
      else if (d < -32768) d = -32768;
      return d[15:0];
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function void note_sample(logic signed [15:0] rx, logic signed [15:0] rz);
      longint    alpha;
      longint    gain;
      longint    lim;
      gtpm_res_t want;
      alpha = (regs.smoothing > ONE_Q16) ? longint'(ONE_Q16) : longint'(regs.smoothing);
      gain  = (regs.pointer_gain > ONE_Q16) ? longint'(ONE_Q16)
                                              : longint'(regs.pointer_gain);
      lim   = longint'(regs.motion_limit) * 256;
      filt_x = smooth_axis(filt_x, rx, regs.bias_x, regs.scale_x, alpha);
      filt_z = smooth_axis(filt_z, rz, regs.bias_z, regs.scale_z, alpha);
      want.delta_h = pointer_delta(filt_z, gain);
      want.delta_v = pointer_delta(filt_x, gain);
      want.moving  = (magnitude(filt_x) > lim) || (magnitude(filt_z) > lim);
      due_motion.push_back(want);
      n_samples++;
    endfunction

    function void report(string what, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic signed [15:0] dh, logic signed [15:0] dv, logic mv);
      gtpm_res_t want;
      if (due_motion.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: beat with nothing expected, expected none, actual h=%0d v=%0d m=%0b",
                   $time, dh, dv, mv);
        return;
      end
      want = due_motion.pop_front();
      n_checked++;
      if (mv) n_moving++;
      if (dh !== want.delta_h) report("delta_h", want.delta_h, dh);
      if (dv !== want.delta_v) report("delta_v", want.delta_v, dv);
      if (mv !== want.moving) report("moving", want.moving, mv);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [31:0]       in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;
  logic [0:0]        out_tuser;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  motion_scoreboard sb = new();
  int burst_left = 0;
  int n_settings = 0;
  int idle_cycles = 0;

  gyro_to_pointer_motion_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[15:0], out_tdata[31:16], out_tuser[0]);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t ns: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side stalls on its own pattern
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       stall;
    out_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(30, 200);
      end
      mode_left--;
      if (stall > 0) begin
        stall--;
        out_tready = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_tready = 1'b1;
          RX_RANDOM: out_tready = 1'($urandom_range(0, 1));
          default: begin
            out_tready = 1'b1;
            if ($urandom_range(0, 7) == 0) stall = $urandom_range(1, 40);
          end
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_regs(input int bx, input int bz, input int sx, input int sz,
                              input int sm, input int gn, input int lim);
    write_reg(REG_BIAS_X, 17'(bx));
    write_reg(REG_BIAS_Z, 17'(bz));
    write_reg(REG_SCALE_X, 17'(sx));
    write_reg(REG_SCALE_Z, 17'(sz));
    write_reg(REG_SMOOTHING, 17'(sm));
    write_reg(REG_POINTER_GAIN, 17'(gn));
    write_reg(REG_MOTION_LIMIT, 17'(lim));
    @(negedge clk);
    cfg_we = 1'b0;
    n_settings++;
  endtask

  task automatic send_sample(input logic [15:0] rx, input logic [15:0] rz);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {rz, rx};
    do @(posedge clk); while (!in_tready);
    sb.note_sample(rx, rz);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.due_motion.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_signed(input int span, input int full_w);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return span;
    if (k == 1) return -span;
    if (k == 2) return int'($urandom_range(0, (1 << full_w) - 1)) - (1 << (full_w - 1));
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_weight();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 65536;
    if (k == 1) return $urandom_range(65537, 131071);
    if (k == 2) return $urandom_range(0, 2048);
    return $urandom_range(0, 65536);
  endfunction

  task automatic program_random_regs();
    int lim;
    case ($urandom_range(0, 5))
      0:       lim = 0;
      1:       lim = 65535;
      default: lim = $urandom_range(0, 40000);
    endcase
    program_regs(pick_signed(25600, 16), pick_signed(25600, 16),
                 pick_signed(40960, 17), pick_signed(40960, 17),
                 pick_weight(), pick_weight(), lim);
  endtask

  // half raw noise, with runs near the bias, held rates and rail values
  function automatic logic [15:0] pick_rate(input logic signed [15:0] bias,
                                            input logic [15:0] prev);
    int k;
    int r;
    k = $urandom_range(0, 9);
    if (k < 5) return 16'($urandom);
    if (k < 7) begin
      r = (int'(bias) >>> 8) + int'($urandom_range(0, 32)) - 16;
      return r[15:0];
    end
    if (k == 7) return prev;
    if (k == 8) return prev + 16'($urandom_range(0, 64)) - 16'd32;
    return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
  endfunction

  initial begin
    logic [15:0] rx;
    logic [15:0] rz;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    rx = '0;
    rz = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset settings, rail and sign extremes
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'hffff, 16'h0001);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);

    // stated range limits of every register
    settle();
    program_regs(25600, -25600, 40960, -40960, 65536, 65536, 65535);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'd100, -16'd100);
    send_sample(16'h0000, 16'h0000);

    // bias and scale beyond range, weight and gain above one, unknown index
    settle();
    program_regs(-32768, 32767, -65536, 65535, 131071, 131071, 0);
    write_reg(REG_SPARE, 17'h1ffff);
    @(negedge clk);
    cfg_we = 1'b0;
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h0000, 16'h0000);

    // zero weight holds the filter, zero gain kills the deltas
    settle();
    program_regs(0, 0, 4096, 4096, 0, 0, 0);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);

    // smallest nonzero weight
    settle();
    program_regs(0, 0, 40960, 40960, 1, 65536, 0);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      program_random_regs();
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        rx = pick_rate(sb.regs.bias_x, rx);
        rz = pick_rate(sb.regs.bias_z, rz);
        send_sample(rx, rz);
      end
    end

    settle();
    $display("%0d gyro samples over %0d register settings, %0d delta beats checked",
             sb.n_samples, n_settings, sb.n_checked);
    $display("%0d beats flagged moving, %0d mismatches", sb.n_moving, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
